[rtl/sse_pkg.sv]
// Shared types and constants for the stepwise sort engine.
// Request items, result items, request and register codes, default sizes.
// No dependencies.
package sse_pkg;

  localparam int DEF_MAX_ELEMENTS = 256;
  localparam int DEF_ELEM_WIDTH   = 32;

  localparam int CNT_W      = 9;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic MODE_BUBBLE = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMS     = 2'd1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        elem_index;
    logic signed [VAL_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic                    moved;
    logic [IDX_W-1:0]        left_index;
    logic                    is_sorted;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

endpackage

[rtl/sse_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/stepwise_sort_engine_core.sv]
// Stepwise sort engine top level: element store, bubble/insertion sequencer, output register.
// Depends on sse_pkg and sse_ram (two mirrored copies of the element store).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | request   | in_valid / in_stall | in_data  (sse_pkg::in_item_t)
//  out_    | result    | out_valid/out_stall | out_data (sse_pkg::out_item_t)
//  cfg_    | reg write | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A request is taken only in idle; reads of both store copies issue at that edge.
// Load, read and non-swapping steps go from idle to execute and back; a swapping bubble step
// also passes through a second write-back state (two write-backs through the single write port).
// A result waiting under out_stall holds the sequencer in its execute cycle.
// Synchronous active-low reset clears progress, registers and the output valid;
// the element store itself is not cleared.
module stepwise_sort_engine_core #(
  parameter int MAX_ELEMENTS = sse_pkg::DEF_MAX_ELEMENTS,
  parameter int ELEM_WIDTH   = sse_pkg::DEF_ELEM_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sse_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sse_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sse_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = sse_pkg::CNT_W;
  localparam logic [16:0] MAXV = 17'(MAX_ELEMENTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WB2  = 2'd2;

  // position modulo store depth, by constant compare-subtract steps
  function automatic logic [AW-1:0] wrap_idx(input logic [CW-1:0] v);
    logic [24:0] r;
    r = 25'(v);
    for (int k = 7; k >= 0; k--) begin
      if (((25'(MAX_ELEMENTS) << k) <= 25'd511) && (r >= (25'(MAX_ELEMENTS) << k))) begin
        r = r - (25'(MAX_ELEMENTS) << k);
      end
    end
    return AW'(r);
  endfunction

  logic [1:0]               state_r, state_nxt;
  logic                     mode_r;
  logic [CW-1:0]            elems_r;
  logic [CW-1:0]            inner_r, inner_nxt;
  logic [CW-1:0]            outer_r, outer_nxt;
  logic [CW-1:0]            insert_r, insert_nxt;
  logic signed [CW:0]       scan_r, scan_nxt;
  logic [ELEM_WIDTH-1:0]    held_r, held_nxt;
  logic                     shift_r, shift_nxt;
  logic                     done_r, done_nxt;
  sse_pkg::in_item_t        item_r;
  logic [AW-1:0]            wb_addr_r, wb_addr_nxt;
  logic [ELEM_WIDTH-1:0]    wb_data_r, wb_data_nxt;
  logic                     out_valid_r;
  sse_pkg::out_item_t       out_data_r;
  sse_pkg::out_item_t       res;

  logic                     accept, out_free, exec_adv;
  logic [sse_pkg::IDX_W-1:0] cur_idx;
  logic [1:0]               cur_req;
  logic [CW-1:0]            n_use;
  logic                     bub_go;
  logic [CW-1:0]            ip;
  logic signed [CW:0]       sp;
  logic [AW-1:0]            idx_addr, bub_a, bub_b, key_addr, sp_addr, sp1_addr;
  logic [AW-1:0]            raddr0, raddr1;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ELEM_WIDTH-1:0]    wdata;
  logic [ELEM_WIDTH-1:0]    rd0, rd1, key;
  logic [63:0]              ext64, rd64;

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_adv  = (state_r == ST_EXEC) && out_free;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_idx = (state_r == ST_IDLE) ? in_data.elem_index : item_r.elem_index;
  assign cur_req = (state_r == ST_IDLE) ? in_data.req_type : item_r.req_type;

  assign n_use  = ({8'b0, elems_r} > MAXV) ? MAXV[CW-1:0] : elems_r;
  assign bub_go = (({1'b0, inner_r} + {1'b0, outer_r} + 10'd1) < {1'b0, n_use});
  assign ip     = (insert_r == '0) ? 9'd1 : insert_r;
  assign sp     = shift_r ? scan_r : ($signed({1'b0, ip}) - 10'sd1);

  assign idx_addr = wrap_idx({1'b0, cur_idx});
  assign bub_a    = wrap_idx(inner_r);
  assign bub_b    = wrap_idx(inner_r + 9'd1);
  assign key_addr = wrap_idx(ip);
  assign sp_addr  = wrap_idx(sp[CW-1:0]);
  assign sp1_addr = wrap_idx(9'(sp + 10'sd1));

  assign raddr0 = (cur_req == sse_pkg::REQ_STEP) ?
                  ((mode_r == sse_pkg::MODE_INSERT) ? key_addr : bub_a) : idx_addr;
  assign raddr1 = (mode_r == sse_pkg::MODE_INSERT) ? sp_addr : bub_b;

  assign ext64 = {{32{item_r.elem_value[31]}}, item_r.elem_value};
  assign rd64  = 64'(rd0);
  assign key   = shift_r ? held_r : rd0;

  sse_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store0 (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (accept),
    .rd_addr (raddr0),
    .rd_data (rd0)
  );

  sse_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store1 (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (accept),
    .rd_addr (raddr1),
    .rd_data (rd1)
  );

  always_comb begin
    state_nxt   = state_r;
    inner_nxt   = inner_r;
    outer_nxt   = outer_r;
    insert_nxt  = insert_r;
    scan_nxt    = scan_r;
    held_nxt    = held_r;
    shift_nxt   = shift_r;
    done_nxt    = done_r;
    wb_addr_nxt = wb_addr_r;
    wb_data_nxt = wb_data_r;
    we          = 1'b0;
    waddr       = idx_addr;
    wdata       = ext64[ELEM_WIDTH-1:0];
    res         = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_adv) begin
          state_nxt = ST_IDLE;
          case (item_r.req_type)
            sse_pkg::REQ_LOAD: begin
              we         = 1'b1;
              inner_nxt  = '0;
              outer_nxt  = '0;
              insert_nxt = '0;
              scan_nxt   = '0;
              held_nxt   = '0;
              shift_nxt  = 1'b0;
              done_nxt   = 1'b0;
            end
            sse_pkg::REQ_STEP: begin
              if (!done_r) begin
                if (mode_r == sse_pkg::MODE_BUBBLE) begin
                  if (bub_go) begin
                    if ($signed(rd1) < $signed(rd0)) begin
                      we             = 1'b1;
                      waddr          = bub_a;
                      wdata          = rd1;
                      wb_addr_nxt    = bub_b;
                      wb_data_nxt    = rd0;
                      state_nxt      = ST_WB2;
                      res.moved      = 1'b1;
                      res.left_index = inner_r[7:0];
                    end
                    inner_nxt = inner_r + 9'd1;
                  end else begin
                    inner_nxt = '0;
                    outer_nxt = outer_r + 9'd1;
                  end
                  done_nxt = (({1'b0, outer_nxt} + 10'd1) >= {1'b0, n_use});
                end else if (n_use < 9'd2) begin
                  done_nxt = 1'b1;
                end else begin
                  insert_nxt = ip;
                  held_nxt   = key;
                  we         = 1'b1;
                  waddr      = sp1_addr;
                  if (!sp[CW] && ($signed(key) < $signed(rd1))) begin
                    wdata          = rd1;
                    scan_nxt       = sp - 10'sd1;
                    shift_nxt      = 1'b1;
                    res.moved      = 1'b1;
                    res.left_index = sp[7:0];
                  end else begin
                    wdata      = key;
                    scan_nxt   = sp;
                    insert_nxt = ip + 9'd1;
                    shift_nxt  = 1'b0;
                  end
                  done_nxt = (insert_nxt >= n_use);
                end
              end
            end
            sse_pkg::REQ_READ: begin
              res.read_value = rd64[31:0];
            end
            default: begin
            end
          endcase
          res.is_sorted = done_nxt;
        end
      end
      ST_WB2: begin
        we        = 1'b1;
        waddr     = wb_addr_r;
        wdata     = wb_data_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= sse_pkg::MODE_BUBBLE;
      elems_r     <= '0;
      inner_r     <= '0;
      outer_r     <= '0;
      insert_r    <= '0;
      scan_r      <= '0;
      held_r      <= '0;
      shift_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inner_r  <= inner_nxt;
      outer_r  <= outer_nxt;
      insert_r <= insert_nxt;
      scan_r   <= scan_nxt;
      held_r   <= held_nxt;
      shift_r  <= shift_nxt;
      done_r   <= done_nxt;
      if (exec_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sse_pkg::CFG_SORT_MODE) begin
          mode_r <= cfg_data[0];
        end else if (cfg_index == sse_pkg::CFG_ELEMS) begin
          elems_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (exec_adv) begin
      out_data_r <= res;
    end
    wb_addr_r <= wb_addr_nxt;
    wb_data_r <= wb_data_nxt;
  end

endmodule

[tb/sv/stepwise_sort_engine_core_tb.sv]
// Self-checking testbench for stepwise_sort_engine_core: bubble and insertion stepping,
// loads, reads, register writes, random idling and output hold-off.
// Depends on sse_pkg and the stepwise_sort_engine_core RTL.
module stepwise_sort_engine_core_tb;

  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam logic [31:0] ELEM_MIN    = 32'h8000_0000;
  localparam logic [31:0] ELEM_MAX    = 32'h7FFF_FFFF;
  localparam int          HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sse_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sse_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the engine
  logic signed [31:0] elem_mem [256];
  int                 bub_inner = 0;
  int                 bub_outer = 0;
  int                 ins_pos = 0;
  int                 scan_ix = 0;
  logic signed [31:0] key_held = '0;
  bit                 shifting = 1'b0;
  bit                 sorted_done = 1'b0;
  logic               mode_reg = sse_pkg::MODE_BUBBLE;
  logic [8:0]         elems_reg = '0;

  sse_pkg::out_item_t sort_outcomes_due [$];
  int        mismatches = 0;
  int        sent_items = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        hold_requests = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  stepwise_sort_engine_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("stepwise_sort_engine_core verification failed");
    $finish;
  end

  function automatic int used_count();
    return (elems_reg > 9'd256) ? 256 : int'(elems_reg);
  endfunction

  function automatic void clear_progress();
    bub_inner = 0;
    bub_outer = 0;
    ins_pos = 0;
    scan_ix = 0;
    key_held = '0;
    shifting = 1'b0;
    sorted_done = 1'b0;
  endfunction

  function automatic bit bubble_move(output int pair_left);
    int n;
    bit mv;
    logic signed [31:0] tmp;
    n = used_count();
    mv = 1'b0;
    pair_left = 0;
    if (bub_inner < n - bub_outer - 1) begin
      if (elem_mem[(bub_inner + 1) & 255] < elem_mem[bub_inner & 255]) begin
        tmp = elem_mem[bub_inner & 255];
        elem_mem[bub_inner & 255] = elem_mem[(bub_inner + 1) & 255];
        elem_mem[(bub_inner + 1) & 255] = tmp;
        pair_left = bub_inner;
        mv = 1'b1;
      end
      bub_inner++;
    end else begin
      bub_inner = 0;
      bub_outer++;
    end
    if (bub_outer >= n - 1) sorted_done = 1'b1;
    return mv;
  endfunction

  function automatic bit insertion_move(output int pair_left);
    int n;
    bit mv;
    n = used_count();
    mv = 1'b0;
    pair_left = 0;
    if (n < 2) begin
      sorted_done = 1'b1;
      return 1'b0;
    end
    if (ins_pos == 0) ins_pos = 1;
    if (!shifting) begin
      key_held = elem_mem[ins_pos & 255];
      scan_ix = ins_pos - 1;
      shifting = 1'b1;
    end
    if (scan_ix >= 0 && key_held < elem_mem[scan_ix & 255]) begin
      elem_mem[(scan_ix + 1) & 255] = elem_mem[scan_ix & 255];
      pair_left = scan_ix;
      mv = 1'b1;
      scan_ix--;
    end else begin
      elem_mem[(scan_ix + 1) & 255] = key_held;
      ins_pos++;
      shifting = 1'b0;
    end
    if (ins_pos >= n) sorted_done = 1'b1;
    return mv;
  endfunction

  function automatic sse_pkg::out_item_t apply_request(input sse_pkg::in_item_t r);
    sse_pkg::out_item_t res;
    int pair_left;
    bit mv;
    res = '0;
    pair_left = 0;
    case (r.req_type)
      sse_pkg::REQ_LOAD: begin
        elem_mem[r.elem_index] = r.elem_value;
        clear_progress();
      end
      sse_pkg::REQ_STEP: begin
        if (!sorted_done) begin
          if (mode_reg == sse_pkg::MODE_INSERT) mv = insertion_move(pair_left);
          else mv = bubble_move(pair_left);
          if (mv) begin
            res.moved = 1'b1;
            res.left_index = pair_left[7:0];
          end
        end
      end
      sse_pkg::REQ_READ: res.read_value = elem_mem[r.elem_index];
      default: ;
    endcase
    res.is_sorted = sorted_done;
    return res;
  endfunction

  function automatic logic [31:0] rand_elem();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return ELEM_MIN;
    if (pick < 16) return ELEM_MAX;
    if (pick < 22) return 32'h0;
    if (pick < 28) return 32'hFFFF_FFFF;
    if (pick < 60) return $urandom_range(8) - 4;
    return $urandom;
  endfunction

  function automatic void compare_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    sse_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (sort_outcomes_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = sort_outcomes_due.pop_front();
        compare_field("moved", 32'(want.moved), 32'(out_data.moved));
        compare_field("left_index", 32'(want.left_index), 32'(out_data.left_index));
        compare_field("is_sorted", 32'(want.is_sorted), 32'(out_data.is_sorted));
        compare_field("read_value", want.read_value, out_data.read_value);
      end
    end
  end

  // receiver stall: random, or a long hold when asked
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [31:0] idx,
                              input logic [31:0] val);
    sse_pkg::in_item_t req;
    req.req_type = kind;
    req.elem_index = idx[7:0];
    req.elem_value = val;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sort_outcomes_due.push_back(apply_request(req));
    sent_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sort_outcomes_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [8:0] count);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= sse_pkg::CFG_SORT_MODE;
    cfg_data <= {8'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_reg = mode;
    cfg_index <= sse_pkg::CFG_ELEMS;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    elems_reg = count;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(REQ_UNKNOWN, 32'hFF, 32'hFFFF_FFFF);
    send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(REQ_UNKNOWN, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_LOAD, 32'd0, ELEM_MAX);
    send_request(sse_pkg::REQ_LOAD, 32'd1, ELEM_MIN);
    send_request(sse_pkg::REQ_LOAD, 32'd2, 32'hFFFF_FFFF);
    send_request(sse_pkg::REQ_LOAD, 32'd3, 32'h0);
    send_request(sse_pkg::REQ_LOAD, 32'd255, ELEM_MIN);
    send_request(sse_pkg::REQ_READ, 32'd255, 32'h0);
    send_request(sse_pkg::REQ_READ, 32'd0, 32'h0);
    // single element: insertion and bubble both report sorted on their first step
    set_config(sse_pkg::MODE_INSERT, 9'd1);
    send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_LOAD, 32'd3, 32'h0);
    set_config(sse_pkg::MODE_BUBBLE, 9'd1);
    send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_LOAD, 32'd3, 32'h0);
    set_config(sse_pkg::MODE_INSERT, 9'd4);
    while (!sorted_done) send_request(sse_pkg::REQ_STEP, 32'h0, 32'h0);
    send_request(sse_pkg::REQ_READ, 32'd3, 32'h0);
    settle();
  endtask

  task automatic test_fill_store();
    int i;
    for (i = 0; i < 256; i++) send_request(sse_pkg::REQ_LOAD, i, rand_elem());
    set_config(sse_pkg::MODE_BUBBLE, 9'd256);
    repeat (12) send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
    // above the store size counts as the full store
    set_config(sse_pkg::MODE_INSERT, 9'h1FF);
    repeat (12) send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
    repeat (4) send_request(sse_pkg::REQ_READ, $urandom, $urandom);
    settle();
  endtask

  task automatic test_random_sorting(input int item_budget);
    int first;
    int n;
    int m;
    int steps;
    int pick;
    int i;
    first = sent_items;
    while (sent_items - first < item_budget) begin
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(10, 2);
      else if (pick < 80) n = $urandom_range(1, 0);
      else if (pick < 92) n = $urandom_range(32, 11);
      else n = 256;
      set_config(logic'($urandom_range(1, 0)), n[8:0]);
      if (n <= 32) begin
        for (i = 0; i < n; i++) send_request(sse_pkg::REQ_LOAD, i, rand_elem());
      end else begin
        repeat (6) send_request(sse_pkg::REQ_LOAD, $urandom, rand_elem());
      end
      steps = 0;
      while (!sorted_done && steps < 150 && sent_items - first < item_budget) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
        end else if (pick < 84) begin
          send_request(sse_pkg::REQ_READ, $urandom, $urandom);
        end else if (pick < 87) begin
          send_request(REQ_UNKNOWN, $urandom, $urandom);
        end else if (pick < 89) begin
          send_request(sse_pkg::REQ_LOAD, $urandom, rand_elem());
        end else if (pick < 92) begin
          // mode or size change in the middle of a sort
          m = $urandom_range((n + 2 > 256) ? 256 : n + 2, 0);
          set_config(logic'($urandom_range(1, 0)), m[8:0]);
        end else if (pick < 94) begin
          settle();
        end else begin
          send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
        end
        steps++;
      end
      repeat (2) send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
      repeat (3) send_request(sse_pkg::REQ_READ, $urandom, $urandom);
    end
    settle();
  endtask

  task automatic test_output_hold();
    int i;
    set_config(sse_pkg::MODE_BUBBLE, 9'd12);
    for (i = 0; i < 12; i++) send_request(sse_pkg::REQ_LOAD, i, rand_elem());
    hold_requests++;
    repeat (20) begin
      if ($urandom_range(3) == 0) send_request(sse_pkg::REQ_READ, $urandom, $urandom);
      else send_request(sse_pkg::REQ_STEP, $urandom, $urandom);
    end
    settle();
  endtask

  initial begin
    in_idle_pct = 32;
    out_idle_pct = 54;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_store();
    test_random_sorting(16);
    test_output_hold();
    in_idle_pct = 54;
    out_idle_pct = 32;
    test_random_sorting(16);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_sorting(16);
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("stepwise_sort_engine_core verification clean");
    end else begin
      $display("stepwise_sort_engine_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sse_pkg.sv
rtl/sse_ram.sv
rtl/stepwise_sort_engine_core.sv
tb/sv/stepwise_sort_engine_core_tb.sv
